// File: hdl/mlm_pkg.sv
// Shared constants and types of the masked line mean block.
package mlm_pkg;

  localparam int MAX_LINE_DEF = 4096;

  localparam int SAMPLE_W = 32;
  localparam int FLAG_W   = 16;
  localparam int MEAN_W   = 32;
  localparam int FRAC_W   = 17;
  localparam int COUNT_W  = 13;
  localparam int FRAC_SHIFT = 16;

  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MEAN,
    BK_FRAC,
    BK_DONE
  } back_state_t;

endpackage

// File: hdl/mlm_pix_if.sv
// Pixel request channel of the masked line mean block.
interface mlm_pix_if import mlm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic [FLAG_W-1:0]          dq_flags;
  logic                       last_in_line;

  modport source (output valid, sample, dq_flags, last_in_line, input ready);
  modport sink (input valid, sample, dq_flags, last_in_line, output ready);
endinterface

// File: hdl/mlm_res_if.sv
// Line result channel of the masked line mean block.
interface mlm_res_if import mlm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [MEAN_W-1:0] mean;
  logic [FRAC_W-1:0]        good_fraction;
  logic [COUNT_W-1:0]       good_count;
  logic                     line_overflow;

  modport source (output valid, mean, good_fraction, good_count, line_overflow, input ready);
  modport sink (input valid, mean, good_fraction, good_count, line_overflow, output ready);
endinterface

// File: hdl/mlm_front.sv
// Front end: takes pixels, applies the bad-flag mask and accumulates line totals.
module mlm_front import mlm_pkg::*; #(
  parameter int MAX_LINE = MAX_LINE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write_en,
  input  logic [FLAG_W-1:0] cfg_write_data,
  mlm_pix_if.sink           pix,
  output logic              rec_valid,
  input  logic              rec_ready,
  output logic [SAMPLE_W+2*$clog2(MAX_LINE+1)+$clog2(MAX_LINE):0] rec_data
);

  localparam int CNT_W = $clog2(MAX_LINE + 1);
  localparam int ACC_W = SAMPLE_W + $clog2(MAX_LINE);

  logic [FLAG_W-1:0]       mask;
  logic signed [ACC_W-1:0] sum_acc;
  logic [CNT_W-1:0]        good_tally;
  logic [CNT_W-1:0]        pixel_tally;
  logic                    overflow_seen;

  logic signed [ACC_W-1:0] sum_acc_next;
  logic [CNT_W-1:0]        good_tally_next;
  logic [CNT_W-1:0]        pixel_tally_next;
  logic                    overflow_seen_next;
  logic                    is_good;
  logic                    at_limit;
  logic                    accept;

  always_comb begin
    is_good            = (pix.dq_flags & mask) == '0;
    at_limit           = pixel_tally == CNT_W'(MAX_LINE);
    sum_acc_next       = sum_acc;
    good_tally_next    = good_tally;
    pixel_tally_next   = pixel_tally;
    overflow_seen_next = overflow_seen;
    if (at_limit) begin
      overflow_seen_next = 1'b1;
    end else begin
      pixel_tally_next = pixel_tally + CNT_W'(1);
      if (is_good) begin
        sum_acc_next    = sum_acc + ACC_W'(pix.sample);
        good_tally_next = good_tally + CNT_W'(1);
      end
    end
  end

  assign pix.ready = rec_ready;
  assign accept    = pix.valid && rec_ready;
  assign rec_valid = accept && pix.last_in_line;
  assign rec_data  = {sum_acc_next, good_tally_next, pixel_tally_next, overflow_seen_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      mask          <= '0;
      sum_acc       <= '0;
      good_tally    <= '0;
      pixel_tally   <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        mask <= cfg_write_data;
      end
      if (accept) begin
        if (pix.last_in_line) begin
          sum_acc       <= '0;
          good_tally    <= '0;
          pixel_tally   <= '0;
          overflow_seen <= 1'b0;
        end else begin
          sum_acc       <= sum_acc_next;
          good_tally    <= good_tally_next;
          pixel_tally   <= pixel_tally_next;
          overflow_seen <= overflow_seen_next;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_pixel_limit: assert property (@(posedge clk) disable iff (rst)
    pixel_tally <= CNT_W'(MAX_LINE))
    else $error("Pixel tally ran past the line limit.");
  a_good_le_pixel: assert property (@(posedge clk) disable iff (rst)
    good_tally <= pixel_tally)
    else $error("Good tally exceeds pixel tally.");
`endif

endmodule

// File: hdl/mlm_queue.sv
// Two-entry queue that carries line totals from the front end to the back end.
module mlm_queue #(
  parameter int W = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] entries [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         do_push;
  logic         do_pop;

  assign push_ready = count != 2'd2;
  assign pop_valid  = count != 2'd0;
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// File: hdl/mlm_back.sv
// Back end: shared restoring divider for mean and good fraction, and the result register.
module mlm_back import mlm_pkg::*; #(
  parameter int MAX_LINE = MAX_LINE_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic rec_valid,
  output logic rec_ready,
  input  logic [SAMPLE_W+2*$clog2(MAX_LINE+1)+$clog2(MAX_LINE):0] rec_data,
  mlm_res_if.source res
);

  localparam int CNT_W = $clog2(MAX_LINE + 1);
  localparam int ACC_W = SAMPLE_W + $clog2(MAX_LINE);
  localparam int CTR_W = $clog2(ACC_W);

  back_state_t state;
  back_state_t state_next;

  logic [ACC_W-1:0] rec_sum;
  logic [CNT_W-1:0] rec_good;
  logic [CNT_W-1:0] rec_pix;
  logic             rec_ovf;
  logic [ACC_W-1:0] sum_mag;

  logic [CNT_W-1:0] divisor;
  logic [CNT_W-1:0] rem;
  logic [ACC_W-1:0] quo;
  logic [CTR_W-1:0] ctr;
  logic             neg;
  logic [CNT_W-1:0] good_r;
  logic [CNT_W-1:0] pix_r;
  logic             ovf_r;
  logic [MEAN_W-1:0] mean_r;
  logic [FRAC_W-1:0] frac_r;

  logic [CNT_W:0]   shifted;
  logic             ge;
  logic [CNT_W:0]   diff;
  logic [CNT_W-1:0] rem_next;
  logic [ACC_W-1:0] quo_next;
  logic [ACC_W-1:0] quo_signed;
  logic [ACC_W-1:0] frac_dividend;
  logic             step_last;
  logic             load_out;

  logic                     out_valid;
  logic signed [MEAN_W-1:0] out_mean;
  logic [FRAC_W-1:0]        out_frac;
  logic [COUNT_W-1:0]       out_count;
  logic                     out_ovf;

  assign {rec_sum, rec_good, rec_pix, rec_ovf} = rec_data;
  assign sum_mag = rec_sum[ACC_W-1] ? (~rec_sum + ACC_W'(1)) : rec_sum;

  assign shifted       = {rem, quo[ACC_W-1]};
  assign ge            = shifted >= {1'b0, divisor};
  assign diff          = shifted - {1'b0, divisor};
  assign rem_next      = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
  assign quo_next      = {quo[ACC_W-2:0], ge};
  assign quo_signed    = neg ? (~quo_next + ACC_W'(1)) : quo_next;
  assign frac_dividend = ACC_W'({good_r, {FRAC_SHIFT{1'b0}}});
  assign step_last     = ctr == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rec_ready  = 1'b0;
    load_out   = 1'b0;
    case (state)
      BK_IDLE: begin
        rec_ready = 1'b1;
        if (rec_valid) begin
          state_next = (rec_good == '0) ? BK_DONE : BK_MEAN;
        end
      end
      BK_MEAN: begin
        if (step_last) begin
          state_next = BK_FRAC;
        end
      end
      BK_FRAC: begin
        if (step_last) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!out_valid || res.ready) begin
          load_out   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        if (rec_valid) begin
          quo     <= sum_mag;
          rem     <= '0;
          divisor <= rec_good;
          ctr     <= CTR_W'(ACC_W - 1);
          neg     <= rec_sum[ACC_W-1];
          good_r  <= rec_good;
          pix_r   <= rec_pix;
          ovf_r   <= rec_ovf;
          mean_r  <= '0;
          frac_r  <= '0;
        end
      end
      BK_MEAN: begin
        if (step_last) begin
          mean_r  <= quo_signed[MEAN_W-1:0];
          quo     <= frac_dividend;
          rem     <= '0;
          divisor <= pix_r;
          ctr     <= CTR_W'(ACC_W - 1);
        end else begin
          quo <= quo_next;
          rem <= rem_next;
          ctr <= ctr - CTR_W'(1);
        end
      end
      BK_FRAC: begin
        quo <= quo_next;
        rem <= rem_next;
        ctr <= ctr - CTR_W'(1);
        if (step_last) begin
          frac_r <= quo_next[FRAC_W-1:0];
        end
      end
      BK_DONE: begin
        if (load_out) begin
          out_mean  <= mean_r;
          out_frac  <= frac_r;
          out_count <= COUNT_W'(good_r);
          out_ovf   <= ovf_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign res.valid         = out_valid;
  assign res.mean          = out_mean;
  assign res.good_fraction = out_frac;
  assign res.good_count    = out_count;
  assign res.line_overflow = out_ovf;

`ifndef SYNTHESIS
  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == BK_MEAN || state == BK_FRAC) |-> divisor != '0)
    else $error("Divider runs with a zero divisor.");
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load_out |=> res.valid)
    else $error("Loaded result is not presented.");
  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.good_fraction <= FRAC_ONE)
    else $error("Good fraction exceeds one.");
  a_empty_skip: assert property (@(posedge clk) disable iff (rst)
    (state == BK_IDLE && rec_valid && rec_good == '0) |=> state == BK_DONE)
    else $error("Line without good pixels did not skip the divider.");
`endif

endmodule

// File: hdl/masked_line_mean.sv
// Top level of the masked line mean block: front end, line queue and divider back end.
// Pixels are taken one per cycle; the front end stalls only while the line queue is full.
// A line with no good pixel skips the divider. The shared divider in the back end forms
// two quotients per line, mean and good fraction, each ACC_W = 32 + clog2(MAX_LINE) bits.
// Synchronous reset clears the mask, the line totals, the queue and the result valid flag.
module masked_line_mean import mlm_pkg::*; #(
  parameter int MAX_LINE = MAX_LINE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write_en,
  input  logic [FLAG_W-1:0] cfg_write_data,
  mlm_pix_if.sink           pix,
  mlm_res_if.source         res
);

  localparam int REC_W = SAMPLE_W + 2 * $clog2(MAX_LINE + 1) + $clog2(MAX_LINE) + 1;

  logic             push_valid;
  logic             push_ready;
  logic [REC_W-1:0] push_data;
  logic             pop_valid;
  logic             pop_ready;
  logic [REC_W-1:0] pop_data;

  mlm_front #(
    .MAX_LINE(MAX_LINE)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .pix           (pix),
    .rec_valid     (push_valid),
    .rec_ready     (push_ready),
    .rec_data      (push_data)
  );

  mlm_queue #(
    .W(REC_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  mlm_back #(
    .MAX_LINE(MAX_LINE)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .rec_valid(pop_valid),
    .rec_ready(pop_ready),
    .rec_data (pop_data),
    .res      (res)
  );

endmodule

// File: dv/tb_masked_line_mean.sv
// Self-checking testbench of the masked line mean block, with directed and random pixel lines.
`timescale 1ns / 1ps

module tb_masked_line_mean;
  import mlm_pkg::*;

  localparam int DRAIN_CYCLES = 2 * (SAMPLE_W + $clog2(MAX_LINE_DEF)) + 30;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int REPORT_LIMIT = 10;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef struct packed {
    logic signed [MEAN_W-1:0] mean;
    logic [FRAC_W-1:0]        good_fraction;
    logic [COUNT_W-1:0]       good_count;
    logic                     line_overflow;
  } line_result_t;

  logic              clk;
  logic              rst;
  logic              cfg_write_en;
  logic [FLAG_W-1:0] cfg_write_data;

  mlm_pix_if pix ();
  mlm_res_if res ();

  masked_line_mean #(.MAX_LINE(MAX_LINE_DEF)) uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .pix            (pix),
    .res            (res)
  );

  logic [FLAG_W-1:0] bad_mask      = '0;
  longint            good_sum      = 0;
  int                good_tally    = 0;
  int                pixel_tally   = 0;
  logic              overflow_seen = 1'b0;
  line_result_t      pending_lines[$];

  int idle_pct      = 0;
  int stall_pct     = 0;
  int hold_len      = 0;
  int cycles        = 0;
  int mismatches    = 0;
  int pixels_sent   = 0;
  int lines_checked = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Line statistics as the block should form them from each accepted pixel.
  function automatic void account_pixel(input logic signed [SAMPLE_W-1:0] sample,
                                        input logic [FLAG_W-1:0] flags, input logic last);
    line_result_t r;
    if (pixel_tally < MAX_LINE_DEF) begin
      pixel_tally++;
      if ((flags & bad_mask) == '0) begin
        good_sum += sample;
        good_tally++;
      end
    end else begin
      overflow_seen = 1'b1;
    end
    if (last) begin
      r.mean = '0;
      r.good_fraction = '0;
      if (good_tally > 0) begin
        r.mean = MEAN_W'(good_sum / longint'(good_tally));
        r.good_fraction = FRAC_W'((longint'(good_tally) << FRAC_SHIFT) / longint'(pixel_tally));
      end
      r.good_count = COUNT_W'(good_tally);
      r.line_overflow = overflow_seen;
      pending_lines.push_back(r);
      good_sum = 0;
      good_tally = 0;
      pixel_tally = 0;
      overflow_seen = 1'b0;
    end
  endfunction

  function automatic void note_mismatch(input string what, input line_result_t want_r,
                                        input line_result_t got_r);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("%s: expected mean %0d frac %0d count %0d ovf %0b,",
               what, want_r.mean, want_r.good_fraction, want_r.good_count,
               want_r.line_overflow);
      $display("  got mean %0d frac %0d count %0d ovf %0b",
               got_r.mean, got_r.good_fraction, got_r.good_count, got_r.line_overflow);
    end
  endfunction

  always @(posedge clk) begin
    line_result_t want_r;
    line_result_t got_r;
    if (!rst && pix.valid && pix.ready) begin
      account_pixel(pix.sample, pix.dq_flags, pix.last_in_line);
      pixels_sent++;
    end
    if (!rst && res.valid && res.ready) begin
      got_r = {res.mean, res.good_fraction, res.good_count, res.line_overflow};
      if (pending_lines.size() == 0) begin
        note_mismatch("unexpected line result", '0, got_r);
      end else begin
        want_r = pending_lines.pop_front();
        lines_checked++;
        if (got_r !== want_r) begin
          note_mismatch("line result mismatch", want_r, got_r);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_len > 0) begin
      hold_len--;
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("run timed out after %0d cycles", cycles);
      $display("masked_line_mean: mismatch");
      $finish;
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 6) return SAMPLE_W'($urandom);
    if (pick == 6) return SAMPLE_MAX;
    if (pick == 7) return SAMPLE_MIN;
    if (pick == 8) return SAMPLE_W'(int'($urandom_range(64)) - 32);
    return {16'($urandom), 16'h0000};
  endfunction

  function automatic logic [FLAG_W-1:0] rand_flags();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 4) return FLAG_W'($urandom) & ~bad_mask;
    if (pick < 8) return FLAG_W'($urandom);
    if (pick == 8) return '0;
    return '1;
  endfunction

  task automatic send_pixel(input logic signed [SAMPLE_W-1:0] sample,
                            input logic [FLAG_W-1:0] flags, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk);
    end
    pix.valid <= 1'b1;
    pix.sample <= sample;
    pix.dq_flags <= flags;
    pix.last_in_line <= last;
    do @(posedge clk); while (!pix.ready);
  endtask

  task automatic send_line(input int len);
    for (int i = 0; i < len; i++) begin
      send_pixel(rand_sample(), rand_flags(), i == len - 1);
    end
  endtask

  task automatic wait_idle();
    pix.valid <= 1'b0;
    @(posedge clk);
    while (pending_lines.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mask(input logic [FLAG_W-1:0] m);
    wait_idle();
    cfg_write_en <= 1'b1;
    cfg_write_data <= m;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    bad_mask = m;
  endtask

  task automatic test_extremes();
    write_mask('0);
    send_pixel(SAMPLE_MAX, '0, 1'b1);
    send_pixel(SAMPLE_MIN, '0, 1'b1);
    send_pixel(SAMPLE_MAX, '0, 1'b0);
    send_pixel(SAMPLE_MAX, '1, 1'b1);
    send_pixel(SAMPLE_MIN, 16'h1234, 1'b0);
    send_pixel(SAMPLE_MIN, 16'h1234, 1'b0);
    send_pixel(SAMPLE_MIN, '0, 1'b1);
    // Negative sums must round toward zero.
    send_pixel(-3, '0, 1'b0);
    send_pixel(0, '0, 1'b1);
    send_pixel(5, '0, 1'b0);
    send_pixel(0, '0, 1'b0);
    send_pixel(0, '0, 1'b1);
  endtask

  task automatic test_masking();
    write_mask('1);
    send_pixel(100, 16'h0001, 1'b0);
    send_pixel(-7, '0, 1'b0);
    send_pixel(1, 16'h8000, 1'b1);
    // A line with no good pixel gives zero mean and zero fraction.
    send_pixel(42, '1, 1'b0);
    send_pixel(SAMPLE_MAX, 16'h0100, 1'b1);
    write_mask(16'h8000);
    send_pixel(9, 16'h7FFF, 1'b0);
    send_pixel(-9, '1, 1'b1);
  endtask

  task automatic test_long_lines();
    idle_pct = 0;
    stall_pct = 0;
    write_mask(16'h0001);
    send_line(100);
    wait_idle();
  endtask

  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    wait_idle();
    hold_len = 3000;
    repeat (30) send_line($urandom_range(1, 3));
    wait_idle();
  endtask

  task automatic test_random_traffic(input int idle, input int stall,
                                     input logic [FLAG_W-1:0] mask, input int n_items);
    int sent;
    int len;
    int unsigned pick;
    sent = 0;
    idle_pct = idle;
    stall_pct = stall;
    write_mask(mask);
    while (sent < n_items) begin
      pick = $urandom_range(19);
      if (pick < 15) len = $urandom_range(1, 6);
      else if (pick < 19) len = $urandom_range(7, 30);
      else len = $urandom_range(60, 120);
      send_line(len);
      sent += len;
    end
    wait_idle();
  endtask

  initial begin
    rst <= 1'b1;
    cfg_write_en <= 1'b0;
    cfg_write_data <= '0;
    pix.valid <= 1'b0;
    pix.sample <= '0;
    pix.dq_flags <= '0;
    pix.last_in_line <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extremes();
    test_masking();
    test_long_lines();
    test_backpressure();
    test_random_traffic(0, 0, 16'h0000, 85);
    test_random_traffic(74, 0, 16'hFFFF, 85);
    test_random_traffic(0, 74, FLAG_W'($urandom), 85);
    test_random_traffic(35, 35, FLAG_W'(1 << $urandom_range(FLAG_W - 1)), 85);
    wait_idle();

    if (pending_lines.size() != 0) begin
      $display("%0d line results never arrived", pending_lines.size());
      mismatches += pending_lines.size();
    end
    $display("Sent %0d pixels and checked %0d line results, including a long line,",
             pixels_sent, lines_checked);
    $display("masks from all-clear to all-set, a long output hold and idle/stall phases.");
    if (mismatches == 0) begin
      $display("masked_line_mean: match");
    end else begin
      $display("masked_line_mean: mismatch");
    end
    $finish;
  end

endmodule
